### rtl/core/cpd_pkg.sv
// Shared constants and types for the closest pair distance unit.
// Used by cpd_scan, cpd_isqrt and closest_pair_distance_unit; depends on nothing.
package cpd_pkg;

  localparam int MAX_POINTS = 64;
  localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int COORD_W    = 16;
  localparam int POINT_W    = 2 * COORD_W;
  localparam int MAG_W      = COORD_W;
  localparam int SQR_W      = 2 * MAG_W;
  localparam int SUM_W      = SQR_W + 1;
  localparam int SQ_W       = 34;
  localparam int FRAC_W     = 8;
  localparam int RAD_W      = SQ_W + 2 * FRAC_W;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 3;
  localparam int STEP_W     = $clog2(ROOT_W);
  localparam int DIST_W     = 25;

  localparam logic [SQ_W-1:0]   SQ_ALL_ONES   = {SQ_W{1'b1}};
  localparam logic [DIST_W-1:0] DIST_ALL_ONES = {DIST_W{1'b1}};

  typedef struct packed {
    logic               start;
    logic               clear;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } scan_cmd_t;

  typedef struct packed {
    logic             done;
    logic             dropped;
    logic [CNT_W-1:0] count;
    logic [SQ_W-1:0]  best;
  } scan_stat_t;

endpackage

### rtl/core/cpd_scan.sv
// Point store and pairwise distance pipeline: read each stored point, square the
// distance to the new point and keep the running minimum. Depends on cpd_pkg.
module cpd_scan
  import cpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  scan_cmd_t  cmd,
  output scan_stat_t stat
);

  logic [POINT_W-1:0] mem [MAX_POINTS];

  logic               busy_r, busy_nxt;
  logic               issue_r, issue_nxt;
  logic [ADDR_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [SQ_W-1:0]    best_r, best_nxt;
  logic               drop_r, drop_nxt;
  logic               done_r, done_nxt;
  logic [COORD_W-1:0] x_r, y_r;
  logic               v1_r, v2_r, v3_r;
  logic [POINT_W-1:0] rd_data_r;
  logic [MAG_W-1:0]   dx_r, dy_r;
  logic [SQR_W-1:0]   sqx_r, sqy_r;

  logic               full;
  logic               finish;
  logic [CNT_W-1:0]   count_last;
  logic [COORD_W:0]   diff_x, diff_y;
  logic [COORD_W:0]   mag_x, mag_y;
  logic [SUM_W-1:0]   sum;

  assign full       = (count_r == CNT_W'(MAX_POINTS));
  assign count_last = count_r - CNT_W'(1);
  assign finish     = busy_r && !issue_r && !v1_r && !v2_r && !v3_r;

  // store read, one entry a cycle while issuing
  always_ff @(posedge clk) begin
    if (issue_r) begin
      rd_data_r <= mem[idx_r];
    end
    if (finish) begin
      mem[count_r[ADDR_W-1:0]] <= {x_r, y_r};
    end
  end

  // absolute coordinate differences
  assign diff_x = {x_r[COORD_W-1], x_r} -
                  {rd_data_r[POINT_W-1], rd_data_r[POINT_W-1:COORD_W]};
  assign diff_y = {y_r[COORD_W-1], y_r} -
                  {rd_data_r[COORD_W-1], rd_data_r[COORD_W-1:0]};
  assign mag_x  = diff_x[COORD_W] ? (~diff_x + 1'b1) : diff_x;
  assign mag_y  = diff_y[COORD_W] ? (~diff_y + 1'b1) : diff_y;
  assign sum    = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_ff @(posedge clk) begin
    if (cmd.start && !busy_r) begin
      x_r <= cmd.x;
      y_r <= cmd.y;
    end
    dx_r  <= mag_x[MAG_W-1:0];
    dy_r  <= mag_y[MAG_W-1:0];
    sqx_r <= dx_r * dx_r;
    sqy_r <= dy_r * dy_r;
  end

  always_comb begin
    busy_nxt  = busy_r;
    issue_nxt = issue_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    best_nxt  = best_r;
    drop_nxt  = drop_r;
    done_nxt  = 1'b0;

    if (cmd.start && !busy_r) begin
      if (full) begin
        drop_nxt = 1'b1;
        done_nxt = 1'b1;
      end else begin
        busy_nxt  = 1'b1;
        issue_nxt = (count_r != '0);
        idx_nxt   = '0;
      end
    end

    if (issue_r) begin
      idx_nxt = idx_r + 1'b1;
      if (CNT_W'(idx_r) == count_last) begin
        issue_nxt = 1'b0;
      end
    end

    if (v3_r && ({{(SQ_W-SUM_W){1'b0}}, sum} < best_r)) begin
      best_nxt = {{(SQ_W-SUM_W){1'b0}}, sum};
    end

    if (finish) begin
      count_nxt = count_r + 1'b1;
      busy_nxt  = 1'b0;
      done_nxt  = 1'b1;
    end

    if (cmd.clear) begin
      count_nxt = '0;
      best_nxt  = SQ_ALL_ONES;
      drop_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      issue_r <= 1'b0;
      idx_r   <= '0;
      count_r <= '0;
      best_r  <= SQ_ALL_ONES;
      drop_r  <= 1'b0;
      done_r  <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      issue_r <= issue_nxt;
      idx_r   <= idx_nxt;
      count_r <= count_nxt;
      best_r  <= best_nxt;
      drop_r  <= drop_nxt;
      done_r  <= done_nxt;
      v1_r    <= issue_r;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
    end
  end

  assign stat.done    = done_r;
  assign stat.dropped = drop_r;
  assign stat.count   = count_r;
  assign stat.best    = best_r;

endmodule

### rtl/core/cpd_isqrt.sv
// Iterative integer square root of the squared distance scaled by 2^16,
// one result bit a cycle. Depends on cpd_pkg.
module cpd_isqrt
  import cpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SQ_W-1:0]   value,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [RAD_W-1:0]   rad_r, rad_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [ROOT_W-1:0]  root_r, root_nxt;

  logic [REM_W-1:0]   rem_sh;
  logic [REM_W-1:0]   trial;

  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = {{(REM_W-ROOT_W-2){1'b0}}, root_r, 2'b01};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(ROOT_W - 1);
      rad_nxt  = {value, {(2*FRAC_W){1'b0}}};
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

### rtl/core/closest_pair_distance_unit.sv
// Closest pair distance unit: top level with request handshakes, sequencing
// and output register. Depends on cpd_pkg, cpd_scan and cpd_isqrt.
//
//   channel | dir | payload
//   --------+-----+------------------------------------------------------------
//   in_     | in  | tdata: point_x[15:0], point_y[31:16]; tlast: last_point
//   out_    | out | tdata: min_distance[24:0], zero[31:25];
//           |     | tuser: pair_found[0], overflowed[1]
//
// A point is compared with every stored entry: the store is read one entry a
// cycle and each read passes a three-stage difference/square/compare pipeline.
// A dropped point (store full) skips the scan. The last point of a set, when at
// least two points are stored, adds the bit-serial square root, then loads the
// output register.
// Reset is synchronous, active low; the store itself is not cleared.
// A result held on out_ while out_tready is low stalls only the next last point.
module closest_pair_distance_unit
  import cpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // point_x[15:0], point_y[31:16]
  input  logic        in_tlast,   // last_point
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // min_distance[24:0], zero pad [31:25]
  output logic [1:0]  out_tuser   // pair_found[0], overflowed[1]
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_ROOT = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic              last_r, last_nxt;
  logic              pair_r, pair_nxt;
  logic              drop_r, drop_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0] out_dist_r;
  logic              out_pair_r, out_drop_r;

  logic              in_acc;
  logic              out_free;
  logic              root_start;
  logic              root_done;
  logic [ROOT_W-1:0] root;
  scan_cmd_t         cmd;
  scan_stat_t        stat;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  cpd_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

  cpd_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .value (stat.best),
    .done  (root_done),
    .root  (root)
  );

  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    pair_nxt      = pair_r;
    drop_nxt      = drop_r;
    dist_nxt      = dist_r;
    out_valid_nxt = out_valid_r;
    root_start    = 1'b0;
    cmd.start     = 1'b0;
    cmd.clear     = 1'b0;
    cmd.x         = in_tdata[COORD_W-1:0];
    cmd.y         = in_tdata[POINT_W-1:COORD_W];

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd.start = 1'b1;
          last_nxt  = in_tlast;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // on the last point, capture the set summary and clear for the next set
        if (stat.done) begin
          if (last_r) begin
            pair_nxt  = (stat.count >= CNT_W'(2));
            drop_nxt  = stat.dropped;
            dist_nxt  = DIST_ALL_ONES;
            cmd.clear = 1'b1;
            if (stat.count >= CNT_W'(2)) begin
              root_start = 1'b1;
              state_nxt  = S_ROOT;
            end else begin
              state_nxt = S_OUT;
            end
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_ROOT: begin
        if (root_done) begin
          dist_nxt  = root[DIST_W-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    pair_r <= pair_nxt;
    drop_r <= drop_nxt;
    dist_r <= dist_nxt;
    if (state_r == S_OUT && out_free) begin
      out_dist_r <= dist_r;
      out_pair_r <= pair_r;
      out_drop_r <= drop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(32-DIST_W){1'b0}}, out_dist_r};
  assign out_tuser  = {out_drop_r, out_pair_r};

endmodule
